>>> src/tx16m_pkg.sv
// Shared types, codes and channel expansion tables for the 16bpp texture decoder.
`default_nettype none

package tx16m_pkg;

    localparam int MAX_PIXELS  = 65536;
    localparam int ADDR_W      = $clog2(MAX_PIXELS);
    localparam int COUNT_W     = ADDR_W + 1;
    localparam int DIM_W       = 9;
    localparam int AREA_W      = 2 * DIM_W;
    localparam int COORD_W     = 8;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;

    // Request actions
    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_READ    = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT = 2'd3;

    // Pixel formats
    localparam logic [7:0] PIX_ARGB1555 = 8'd0;
    localparam logic [7:0] PIX_RGB565   = 8'd1;
    localparam logic [7:0] PIX_ARGB4444 = 8'd2;

    // Layouts
    localparam logic [7:0] LAYOUT_TWIDDLED = 8'd1;
    localparam logic [7:0] LAYOUT_LINEAR   = 8'd9;

    // Result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_SIZE    = 3'd1;
    localparam logic [2:0] ST_BAD_PIXEL  = 3'd2;
    localparam logic [2:0] ST_BAD_LAYOUT = 3'd3;
    localparam logic [2:0] ST_SHORT      = 3'd4;
    localparam logic [2:0] ST_RANGE      = 3'd5;

    localparam int C_MAX5  = 31;
    localparam int C_MAX6  = 63;
    localparam int C_FULL8 = 255;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] texel_word;
        logic [15:0] out_index;
    } t_req;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [2:0] status;
    } t_res;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [7:0]       pixel_format;
        logic [7:0]       layout_format;
    } t_cfg;

    // One entry of the queue between the front and back ends.
    typedef struct packed {
        logic              is_write;
        logic [ADDR_W-1:0] addr;
        logic [15:0]       data;
        logic [2:0]        status;
        logic              blank;
        logic [1:0]        fmt;
    } t_job;

    typedef logic [31:0][7:0] t_lut5;
    typedef logic [63:0][7:0] t_lut6;

    function automatic t_lut5 build_lut5();
        t_lut5 lut;
        for (int i = 0; i < 32; i++) begin
            lut[i] = 8'((i * C_FULL8) / C_MAX5);
        end
        return lut;
    endfunction

    function automatic t_lut6 build_lut6();
        t_lut6 lut;
        for (int i = 0; i < 64; i++) begin
            lut[i] = 8'((i * C_FULL8) / C_MAX6);
        end
        return lut;
    endfunction

    localparam t_lut5 LUT5 = build_lut5();
    localparam t_lut6 LUT6 = build_lut6();

endpackage

`default_nettype wire

>>> src/texture_16bpp_to_rgba8_morton_core.sv
// Top level of the 16bpp texture to RGBA8 decoder with Morton addressing.
//
//   Channel   Ports                                   Transfer
//   request   start, busy, i_req                      taken when start && !busy
//   result    o_valid, o_res                          one cycle, receiver cannot stall
//   config    i_cfg_we, i_cfg_idx, i_cfg_data         written when i_cfg_we is high
//
// One request can be taken every cycle while busy is low. A read result follows its
// request through the queue, then the texel store read, then channel expansion into
// the output register.
// Loads, restarts and unused actions give no result. Reset is synchronous and
// clears the load position, queue and configuration; the texel store is not cleared.
// busy rises only if the request queue fills, which the always-draining back end prevents.
`default_nettype none

module texture_16bpp_to_rgba8_morton_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire tx16m_pkg::t_req                     i_req,
    output logic                                     o_valid,
    output tx16m_pkg::t_res                          o_res,
    input  wire logic                                i_cfg_we,
    input  wire logic [tx16m_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [tx16m_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    tx16m_pkg::t_cfg r_cfg;
    tx16m_pkg::t_job front_job;
    tx16m_pkg::t_job queue_job;
    logic            accept;
    logic            push;
    logic            pop;
    logic            empty;
    logic            full;

    assign busy   = full;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width         <= '0;
            r_cfg.height        <= '0;
            r_cfg.pixel_format  <= tx16m_pkg::PIX_ARGB1555;
            r_cfg.layout_format <= tx16m_pkg::LAYOUT_TWIDDLED;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tx16m_pkg::CFG_WIDTH:  r_cfg.width         <= i_cfg_data;
                tx16m_pkg::CFG_HEIGHT: r_cfg.height        <= i_cfg_data;
                tx16m_pkg::CFG_PIXEL:  r_cfg.pixel_format  <= i_cfg_data[7:0];
                tx16m_pkg::CFG_LAYOUT: r_cfg.layout_format <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    tx16m_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_req),
        .i_cfg    (r_cfg),
        .o_job    (front_job),
        .o_push   (push)
    );

    tx16m_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_empty (empty),
        .o_full  (full)
    );

    tx16m_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (queue_job),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    // Every accepted read produces exactly one result.
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.action == tx16m_pkg::ACT_READ) |-> ##3 o_valid)
        else $error("read request without a result three cycles later");

    // Requests that are not reads never produce a result.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!(accept && i_req.action == tx16m_pkg::ACT_READ)) |-> ##3 !o_valid)
        else $error("result without a matching read request");

    // Failed reads return all channels as zero.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.status != tx16m_pkg::ST_OK) |->
        (o_res.red == '0 && o_res.green == '0 && o_res.blue == '0 && o_res.alpha == '0))
        else $error("error result with nonzero channels");

    // The back end drains the queue at least as fast as it fills.
    a_no_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("request queue filled up");

endmodule

`default_nettype wire

>>> src/tx16m_front.sv
// Front end: classifies requests, tracks the load position and forms queue entries.
`default_nettype none

module tx16m_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire tx16m_pkg::t_req  i_req,
    input  wire tx16m_pkg::t_cfg  i_cfg,
    output tx16m_pkg::t_job       o_job,
    output logic                  o_push
);

    logic [tx16m_pkg::COUNT_W-1:0] r_load_count;
    logic [tx16m_pkg::COUNT_W-1:0] n_load_count;
    logic [tx16m_pkg::AREA_W-1:0]  area;
    logic [tx16m_pkg::COORD_W-1:0] pos_x;
    logic [tx16m_pkg::COORD_W-1:0] pos_y;
    logic [tx16m_pkg::COUNT_W-1:0] twiddle_src;
    logic                          store_full;
    logic                          twiddled;
    logic                          outside;
    logic [2:0]                    status;

    assign area = tx16m_pkg::AREA_W'(i_cfg.width) * tx16m_pkg::AREA_W'(i_cfg.height);

    // Morton de-interleave: even index bits give x, odd bits give y.
    always_comb begin
        for (int k = 0; k < tx16m_pkg::COORD_W; k++) begin
            pos_x[k] = i_req.out_index[2*k];
            pos_y[k] = i_req.out_index[2*k+1];
        end
    end

    assign twiddle_src = tx16m_pkg::COUNT_W'(pos_y) * tx16m_pkg::COUNT_W'(i_cfg.width)
                       + tx16m_pkg::COUNT_W'(pos_x);
    assign twiddled    = (i_cfg.layout_format == tx16m_pkg::LAYOUT_TWIDDLED);
    assign outside     = twiddled && ((tx16m_pkg::DIM_W'(pos_x) >= i_cfg.width) ||
                                      (tx16m_pkg::DIM_W'(pos_y) >= i_cfg.height));
    assign store_full  = (r_load_count == tx16m_pkg::COUNT_W'(tx16m_pkg::MAX_PIXELS));

    always_comb begin
        if (i_cfg.width == '0 || i_cfg.height == '0) begin
            status = tx16m_pkg::ST_NO_SIZE;
        end else if (i_cfg.pixel_format > tx16m_pkg::PIX_ARGB4444) begin
            status = tx16m_pkg::ST_BAD_PIXEL;
        end else if (!twiddled && i_cfg.layout_format != tx16m_pkg::LAYOUT_LINEAR) begin
            status = tx16m_pkg::ST_BAD_LAYOUT;
        end else if (tx16m_pkg::AREA_W'(r_load_count) < area) begin
            status = tx16m_pkg::ST_SHORT;
        end else if (tx16m_pkg::AREA_W'(i_req.out_index) >= area) begin
            status = tx16m_pkg::ST_RANGE;
        end else begin
            status = tx16m_pkg::ST_OK;
        end
    end

    always_comb begin
        n_load_count = r_load_count;
        o_push       = 1'b0;
        o_job        = '0;
        o_job.data   = i_req.texel_word;
        o_job.fmt    = i_cfg.pixel_format[1:0];
        o_job.status = status;
        o_job.blank  = (status != tx16m_pkg::ST_OK) || outside;
        if (i_accept) begin
            case (i_req.action)
                tx16m_pkg::ACT_LOAD: begin
                    if (!store_full) begin
                        o_push         = 1'b1;
                        o_job.is_write = 1'b1;
                        o_job.addr     = r_load_count[tx16m_pkg::ADDR_W-1:0];
                        n_load_count   = r_load_count + 1'b1;
                    end
                end
                tx16m_pkg::ACT_READ: begin
                    o_push     = 1'b1;
                    // The status checks keep the address of every read that is not blanked below the load count.
                    o_job.addr = twiddled ? twiddle_src[tx16m_pkg::ADDR_W-1:0]
                                          : i_req.out_index;
                end
                tx16m_pkg::ACT_RESTART: begin
                    n_load_count = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_count <= '0;
        end else begin
            r_load_count <= n_load_count;
        end
    end

endmodule

`default_nettype wire

>>> src/tx16m_fifo.sv
// Short request queue between the front and back ends.
`default_nettype none

module tx16m_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire tx16m_pkg::t_job i_job,
    input  wire logic            i_pop,
    output tx16m_pkg::t_job      o_job,
    output logic                 o_empty,
    output logic                 o_full
);

    tx16m_pkg::t_job                  r_slot [tx16m_pkg::FIFO_DEPTH];
    logic [tx16m_pkg::FIFO_PTR_W-1:0] r_wr_ptr;
    logic [tx16m_pkg::FIFO_PTR_W-1:0] r_rd_ptr;
    logic [tx16m_pkg::FIFO_CNT_W-1:0] r_count;
    logic                             do_push;
    logic                             do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == tx16m_pkg::FIFO_CNT_W'(tx16m_pkg::FIFO_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + tx16m_pkg::FIFO_CNT_W'(do_push)
                               - tx16m_pkg::FIFO_CNT_W'(do_pop);
        end
    end

endmodule

`default_nettype wire

>>> src/tx16m_back.sv
// Back end: texel store writes, texel fetch and channel expansion to RGBA8.
`default_nettype none

module tx16m_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_empty,
    input  wire tx16m_pkg::t_job i_job,
    output logic                 o_pop,
    output logic                 o_valid,
    output tx16m_pkg::t_res      o_res
);

    logic [15:0] r_mem [tx16m_pkg::MAX_PIXELS];
    logic [15:0] r_texel;
    logic        r_s1_valid;
    logic [2:0]  r_s1_status;
    logic        r_s1_blank;
    logic [1:0]  r_s1_fmt;
    tx16m_pkg::t_res n_res;

    // The back end never stalls, so it drains one entry per cycle while the queue is not empty.
    assign o_pop = !i_empty;

    always_ff @(posedge i_clk) begin
        if (o_pop && i_job.is_write) begin
            r_mem[i_job.addr] <= i_job.data;
        end
        if (o_pop && !i_job.is_write) begin
            r_texel <= r_mem[i_job.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_status <= i_job.status;
        r_s1_blank  <= i_job.blank;
        r_s1_fmt    <= i_job.fmt;
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= o_pop && !i_job.is_write;
        end
    end

    always_comb begin
        n_res        = '0;
        n_res.status = r_s1_status;
        case (r_s1_fmt)
            tx16m_pkg::PIX_ARGB1555[1:0]: begin
                n_res.red   = tx16m_pkg::LUT5[r_texel[14:10]];
                n_res.green = tx16m_pkg::LUT5[r_texel[9:5]];
                n_res.blue  = tx16m_pkg::LUT5[r_texel[4:0]];
                n_res.alpha = {8{r_texel[15]}};
            end
            tx16m_pkg::PIX_RGB565[1:0]: begin
                n_res.red   = tx16m_pkg::LUT5[r_texel[15:11]];
                n_res.green = tx16m_pkg::LUT6[r_texel[10:5]];
                n_res.blue  = tx16m_pkg::LUT5[r_texel[4:0]];
                n_res.alpha = 8'hFF;
            end
            default: begin
                // Multiplying a nibble by 17 repeats it in both halves of the byte.
                n_res.red   = {2{r_texel[11:8]}};
                n_res.green = {2{r_texel[7:4]}};
                n_res.blue  = {2{r_texel[3:0]}};
                n_res.alpha = {2{r_texel[15:12]}};
            end
        endcase
        if (r_s1_blank) begin
            n_res.red   = '0;
            n_res.green = '0;
            n_res.blue  = '0;
            n_res.alpha = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        o_res <= n_res;
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_s1_valid;
        end
    end

endmodule

`default_nettype wire

>>> bench/tb_texture_16bpp_to_rgba8_morton_core.sv
// Self-checking testbench for the 16bpp texture to RGBA8 Morton decoder core.
`timescale 1ns / 100ps

module tb_texture_16bpp_to_rgba8_morton_core;

    localparam logic [1:0] ACT_IGNORED  = 2'd3;
    localparam int         RANDOM_ITEMS = 1850;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         DRAIN_CYCLES = 6;

    // Tracks the decoder state and queues the pixel each accepted read must produce.
    class texel_decode_model;
        logic [15:0]                 texels [tx16m_pkg::MAX_PIXELS];
        int unsigned                 loaded;
        logic [tx16m_pkg::DIM_W-1:0] width;
        logic [tx16m_pkg::DIM_W-1:0] height;
        logic [7:0]                  pix_fmt;
        logic [7:0]                  layout;
        tx16m_pkg::t_res             pending [$];
        int unsigned                 errors;
        int unsigned                 reads_checked;
        int unsigned                 loads_taken;
        int unsigned                 loads_dropped;
        int unsigned                 status_seen [8];

        function new();
            loaded        = 0;
            width         = '0;
            height        = '0;
            pix_fmt       = tx16m_pkg::PIX_ARGB1555;
            layout        = tx16m_pkg::LAYOUT_TWIDDLED;
            errors        = 0;
            reads_checked = 0;
            loads_taken   = 0;
            loads_dropped = 0;
            foreach (status_seen[k]) status_seen[k] = 0;
        endfunction

        function void set_register(logic [tx16m_pkg::CFG_IDX_W-1:0] idx,
                                   logic [tx16m_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                tx16m_pkg::CFG_WIDTH:  width   = data;
                tx16m_pkg::CFG_HEIGHT: height  = data;
                tx16m_pkg::CFG_PIXEL:  pix_fmt = data[7:0];
                tx16m_pkg::CFG_LAYOUT: layout  = data[7:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] scale5(logic [4:0] v);
            return 8'(int'(v) * 255 / 31);
        endfunction

        function tx16m_pkg::t_res decode_pixel(logic [15:0] idx);
            tx16m_pkg::t_res px;
            int unsigned     area;
            int unsigned     src;
            logic [7:0]      x;
            logic [7:0]      y;
            logic [15:0]     p;
            px   = '0;
            area = int'(width) * int'(height);
            if (width == 0 || height == 0) begin
                px.status = tx16m_pkg::ST_NO_SIZE;
            end else if (pix_fmt > tx16m_pkg::PIX_ARGB4444) begin
                px.status = tx16m_pkg::ST_BAD_PIXEL;
            end else if (layout != tx16m_pkg::LAYOUT_TWIDDLED &&
                         layout != tx16m_pkg::LAYOUT_LINEAR) begin
                px.status = tx16m_pkg::ST_BAD_LAYOUT;
            end else if (loaded < area) begin
                px.status = tx16m_pkg::ST_SHORT;
            end else if (idx >= area) begin
                px.status = tx16m_pkg::ST_RANGE;
            end else begin
                px.status = tx16m_pkg::ST_OK;
                src = 32'(idx);
                if (layout == tx16m_pkg::LAYOUT_TWIDDLED) begin
                    // Even index bits form x, odd bits form y.
                    for (int b = 0; b < 8; b++) begin
                        x[b] = idx[2*b];
                        y[b] = idx[2*b+1];
                    end
                    // A position past the image edge reads as a blank pixel.
                    if (x >= width || y >= height) return px;
                    src = int'(y) * int'(width) + int'(x);
                end
                p = texels[src];
                case (pix_fmt)
                    tx16m_pkg::PIX_ARGB1555: begin
                        px.red   = scale5(p[14:10]);
                        px.green = scale5(p[9:5]);
                        px.blue  = scale5(p[4:0]);
                        px.alpha = p[15] ? 8'hFF : 8'h00;
                    end
                    tx16m_pkg::PIX_RGB565: begin
                        px.red   = scale5(p[15:11]);
                        px.green = 8'(int'(p[10:5]) * 255 / 63);
                        px.blue  = scale5(p[4:0]);
                        px.alpha = 8'hFF;
                    end
                    default: begin
                        px.red   = 8'(int'(p[11:8]) * 17);
                        px.green = 8'(int'(p[7:4]) * 17);
                        px.blue  = 8'(int'(p[3:0]) * 17);
                        px.alpha = 8'(int'(p[15:12]) * 17);
                    end
                endcase
            end
            return px;
        endfunction

        function void take_request(tx16m_pkg::t_req r);
            case (r.action)
                tx16m_pkg::ACT_LOAD: begin
                    if (loaded < tx16m_pkg::MAX_PIXELS) begin
                        texels[loaded] = r.texel_word;
                        loaded++;
                        loads_taken++;
                    end else begin
                        loads_dropped++;
                    end
                end
                tx16m_pkg::ACT_RESTART: loaded = 0;
                tx16m_pkg::ACT_READ:    pending = {pending, decode_pixel(r.out_index)};
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_pixel(tx16m_pkg::t_res got);
            tx16m_pkg::t_res want;
            if (pending.size() == 0) begin
                $display("%0t: pixel result with no read pending, expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            reads_checked++;
            status_seen[want.status]++;
            compare_field("red", want.red, got.red);
            compare_field("green", want.green, got.green);
            compare_field("blue", want.blue, got.blue);
            compare_field("alpha", want.alpha, got.alpha);
            compare_field("status", 8'(want.status), 8'(got.status));
        endfunction
    endclass

    logic                             i_clk      = 1'b0;
    logic                             i_rst_n    = 1'b0;
    logic                             start      = 1'b0;
    logic                             busy;
    tx16m_pkg::t_req                  i_req      = '0;
    logic                             o_valid;
    tx16m_pkg::t_res                  o_res;
    logic                             i_cfg_we   = 1'b0;
    logic [tx16m_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [tx16m_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    texel_decode_model golden = new();
    bit                idle_on = 1'b1;
    int unsigned       stall_cycles = 0;
    int unsigned       settings_run = 0;

    texture_16bpp_to_rgba8_morton_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Requests are noted before results are checked, so ordering within an edge is fixed.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) golden.take_request(i_req);
        if (i_rst_n && o_valid) golden.check_pixel(o_res);
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no request or result for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send(logic [1:0] act, logic [15:0] word, logic [15:0] index);
        int gap;
        gap = idle_on ? int'($urandom_range(0, 19)) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= '{action: act, texel_word: word, out_index: index};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Loads give no result, so after the last pending read the bench idles DRAIN_CYCLES to let them retire.
    task automatic settle();
        start <= 1'b0;
        while (golden.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(logic [tx16m_pkg::CFG_IDX_W-1:0] idx,
                           logic [tx16m_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        golden.set_register(idx, data);
    endtask

    task automatic program_regs(input logic [tx16m_pkg::DIM_W-1:0] w,
                                input logic [tx16m_pkg::DIM_W-1:0] h,
                                input logic [7:0] pf, input logic [7:0] lay);
        settle();
        put_reg(tx16m_pkg::CFG_WIDTH, w);
        put_reg(tx16m_pkg::CFG_HEIGHT, h);
        // The top data bit is unused by the byte-wide registers; drive it randomly anyway.
        put_reg(tx16m_pkg::CFG_PIXEL, {1'($urandom_range(0, 1)), pf});
        put_reg(tx16m_pkg::CFG_LAYOUT, {1'($urandom_range(0, 1)), lay});
        i_cfg_we <= 1'b0;
        settings_run++;
    endtask

    initial begin
        logic [15:0]                 corner_texels [8] = '{16'h0000, 16'hFFFF, 16'h8000,
                                                           16'h7FFF, 16'hF800, 16'h07E0,
                                                           16'h001F, 16'h0F0F};
        logic [15:0]                 corner_reads [6]  = '{16'd0, 16'd1, 16'd4, 16'd7,
                                                           16'd8, 16'hFFFF};
        logic [tx16m_pkg::DIM_W-1:0] w;
        logic [tx16m_pkg::DIM_W-1:0] h;
        logic [7:0]                  pf;
        logic [7:0]                  lay;
        logic [15:0]                 index;
        int unsigned                 area;
        int unsigned                 fed;
        int unsigned                 loads;
        int unsigned                 pick;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: error priority, a 2x4 twiddled image with reads past its right edge,
        // range checks, the unused action and a restart.
        send(tx16m_pkg::ACT_READ, 16'hFFFF, 16'h0000);
        program_regs(9'd4, 9'd0, tx16m_pkg::PIX_ARGB1555, tx16m_pkg::LAYOUT_TWIDDLED);
        send(tx16m_pkg::ACT_READ, 16'h0000, 16'd3);
        program_regs(9'd4, 9'd4, 8'hFF, tx16m_pkg::LAYOUT_TWIDDLED);
        send(tx16m_pkg::ACT_READ, 16'h0000, 16'd0);
        program_regs(9'd4, 9'd4, tx16m_pkg::PIX_ARGB1555, 8'h00);
        send(tx16m_pkg::ACT_READ, 16'h0000, 16'd0);
        program_regs(9'd2, 9'd4, tx16m_pkg::PIX_ARGB1555, tx16m_pkg::LAYOUT_TWIDDLED);
        send(tx16m_pkg::ACT_READ, 16'h0000, 16'd0);
        foreach (corner_texels[k]) send(tx16m_pkg::ACT_LOAD, corner_texels[k], 16'hFFFF);
        foreach (corner_reads[k]) send(tx16m_pkg::ACT_READ, 16'h0000, corner_reads[k]);
        send(ACT_IGNORED, 16'hFFFF, 16'hFFFF);
        send(tx16m_pkg::ACT_RESTART, 16'h0000, 16'h0000);
        send(tx16m_pkg::ACT_READ, 16'h0000, 16'd0);

        // Images bigger than the store can never be fully loaded.
        program_regs(9'd257, 9'd256, tx16m_pkg::PIX_RGB565, tx16m_pkg::LAYOUT_LINEAR);
        send(tx16m_pkg::ACT_READ, 16'($urandom), 16'($urandom));
        program_regs(9'd511, 9'd511, tx16m_pkg::PIX_ARGB4444, tx16m_pkg::LAYOUT_TWIDDLED);
        send(tx16m_pkg::ACT_READ, 16'($urandom), 16'($urandom));

        // Random settings, each mostly a restart, a full image load and reads.
        fed = 0;
        while (fed < RANDOM_ITEMS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0: begin
                    w = '0;
                    h = 9'($urandom_range(0, 511));
                end
                1: begin
                    w = 9'($urandom_range(1, 511));
                    h = '0;
                end
                2: begin
                    w = 9'($urandom_range(0, 511));
                    h = 9'($urandom_range(0, 511));
                end
                3: begin
                    w = $urandom_range(0, 1) ? 9'd511 : 9'd256;
                    h = 9'd1;
                    if ($urandom_range(0, 1)) {w, h} = {h, w};
                end
                default: begin
                    w = 9'($urandom_range(1, 12));
                    h = 9'($urandom_range(1, 12));
                end
            endcase
            if ($urandom_range(0, 4) != 0) begin
                pf = 8'($urandom_range(0, 2));
            end else begin
                pf = $urandom_range(0, 1) ? 8'hFF : 8'($urandom_range(3, 255));
            end
            if ($urandom_range(0, 4) != 0) begin
                lay = $urandom_range(0, 1) ? tx16m_pkg::LAYOUT_TWIDDLED
                                           : tx16m_pkg::LAYOUT_LINEAR;
            end else begin
                lay = 8'($urandom_range(0, 255));
            end
            program_regs(w, h, pf, lay);
            area = int'(w) * int'(h);

            if (area <= 600 && $urandom_range(0, 4) != 0) begin
                if ($urandom_range(0, 9) != 0) begin
                    send(tx16m_pkg::ACT_RESTART, 16'($urandom), 16'($urandom));
                    fed++;
                end
                loads = area + $urandom_range(0, 3);
            end else begin
                loads = $urandom_range(0, 8);
            end
            repeat (loads) begin
                send(tx16m_pkg::ACT_LOAD, 16'($urandom), 16'($urandom));
                fed++;
            end

            repeat ($urandom_range(10, 40)) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    send(ACT_IGNORED, 16'($urandom), 16'($urandom));
                end else if (pick < 7) begin
                    send(tx16m_pkg::ACT_LOAD, 16'($urandom), 16'($urandom));
                    fed++;
                end else if (pick < 9) begin
                    send(tx16m_pkg::ACT_RESTART, 16'($urandom), 16'($urandom));
                    fed++;
                end else begin
                    if (pick < 75 && area > 0) begin
                        index = 16'($urandom_range(0, area - 1));
                    end else if (pick < 85) begin
                        index = 16'(area);
                    end else begin
                        index = 16'($urandom);
                    end
                    send(tx16m_pkg::ACT_READ, 16'($urandom), index);
                    fed++;
                end
            end
        end

        settle();
        $display("Covered %0d register settings: %0d pixel reads checked, %0d loads, %0d dropped.",
                 settings_run, golden.reads_checked, golden.loads_taken, golden.loads_dropped);
        $display("Read status mix: ok %0d, no size %0d, bad pixel %0d, bad layout %0d, %s %0d, %s %0d",
                 golden.status_seen[tx16m_pkg::ST_OK], golden.status_seen[tx16m_pkg::ST_NO_SIZE],
                 golden.status_seen[tx16m_pkg::ST_BAD_PIXEL],
                 golden.status_seen[tx16m_pkg::ST_BAD_LAYOUT],
                 "short", golden.status_seen[tx16m_pkg::ST_SHORT],
                 "range", golden.status_seen[tx16m_pkg::ST_RANGE]);
        if (golden.errors == 0 && golden.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
